@@ rtl/gpr_pkg.sv @@
// Shared constants and the pipeline word type for the GF(2) polynomial remainder block.
// Depends on nothing; every other file refers to it by scoped names.
package gpr_pkg;

  localparam int DEGREE     = 16;
  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = 16;
  localparam int REM_W      = 16;

  // Working widths follow the polynomial degree.
  localparam int NUM_W = DEGREE + 1;
  localparam int DEN_W = DEGREE;
  localparam int CNT_W = $clog2(DEGREE + 2);

  // One word as it travels down the chain of reduction cells.
  typedef struct packed {
    logic [NUM_W-1:0] num;    // partial remainder
    logic [NUM_W-1:0] den;    // divisor, leading term aligned to probe
    logic [NUM_W-1:0] probe;  // one-hot bit the current cell examines
    logic [CNT_W-1:0] cnt;    // reduction steps still to do
    logic             zero;   // divisor was the zero polynomial
  } pkt_t;

endpackage

@@ rtl/gf2_poly_remainder.sv @@
// Pipeline: one alignment stage, then one register per reduction cell in a chain of
// DEGREE+1 cells. Throughput: one word per cycle while out_stall is low; every stage
// has its own valid bit, so bubbles close up and a new word is taken while a finished
// one waits at the output.
// Reset: synchronous, active low, clears the valid bits only; the data registers are not reset.
module gf2_poly_remainder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gpr_pkg::DIVIDEND_W-1:0] in_dividend,
  input  logic [gpr_pkg::DIVISOR_W-1:0]  in_divisor,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gpr_pkg::REM_W-1:0]      out_remainder,
  output logic                           out_divisible,
  output logic                           out_divisor_zero
);

  localparam int NS = gpr_pkg::NUM_W;

  gpr_pkg::pkt_t stg_pkt [NS+1];
  logic [NS:0]   stg_v;
  logic [NS+1:0] rdy;

  assign rdy[NS+1] = !out_stall;

  gpr_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_rdy   (rdy[0]),
    .dividend (in_dividend),
    .divisor  (in_divisor),
    .dn_valid (stg_v[0]),
    .dn_rdy   (rdy[1]),
    .dn_pkt   (stg_pkt[0])
  );

  for (genvar k = 1; k <= NS; k++) begin : g_cell
    gpr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_v[k-1]),
      .up_rdy   (rdy[k]),
      .up_pkt   (stg_pkt[k-1]),
      .dn_valid (stg_v[k]),
      .dn_rdy   (rdy[k+1]),
      .dn_pkt   (stg_pkt[k])
    );
  end

  assign in_stall         = !rdy[0];
  assign out_valid        = stg_v[NS];
  assign out_remainder    = gpr_pkg::REM_W'(stg_pkt[NS].num);
  assign out_divisible    = !stg_pkt[NS].zero && (stg_pkt[NS].num == '0);
  assign out_divisor_zero = stg_pkt[NS].zero;

  // Every reduction step must have been done by the end of the chain.
  a_steps_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (stg_pkt[NS].cnt == '0))
    else $error("word left the chain with reduction steps outstanding");

  // The input is only held off when the whole chain is full behind a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&stg_v)))
    else $error("input stalled while the chain had room");

  // A zero divisor gives a cleared remainder and never reports divisibility.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divisor_zero) |-> (out_remainder == '0 && !out_divisible))
    else $error("zero divisor produced a non-zero result");

  // A word taken in is present in the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> stg_v[0])
    else $error("accepted word did not enter the alignment stage");

endmodule

@@ rtl/gpr_norm.sv @@
// Front stage: masks the operands, finds the divisor's leading term and aligns it.
// Depends on gpr_pkg; feeds the first gpr_cell.
module gpr_norm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_rdy,
  input  logic [gpr_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [gpr_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            dn_valid,
  input  logic                            dn_rdy,
  output gpr_pkg::pkt_t                   dn_pkt
);

  logic [gpr_pkg::DEN_W-1:0] den;
  logic [gpr_pkg::CNT_W-1:0] dtop;
  logic [gpr_pkg::CNT_W-1:0] sh;
  logic                      zero;
  gpr_pkg::pkt_t             pkt_nxt;
  gpr_pkg::pkt_t             pkt_r;
  logic                      valid_r;

  always_comb begin
    den  = gpr_pkg::DEN_W'(divisor);
    zero = (den == '0);
    dtop = '0;
    for (int i = 0; i < gpr_pkg::DEN_W; i++) begin
      if (den[i]) begin
        dtop = gpr_pkg::CNT_W'(i);
      end
    end
    sh = gpr_pkg::CNT_W'(gpr_pkg::DEGREE) - dtop;

    // A zero divisor enters with no steps to do and a cleared dividend.
    pkt_nxt.num   = zero ? '0 : gpr_pkg::NUM_W'(dividend);
    pkt_nxt.den   = gpr_pkg::NUM_W'(den) << sh;
    pkt_nxt.probe = {1'b1, {(gpr_pkg::NUM_W-1){1'b0}}};
    pkt_nxt.cnt   = zero ? '0 : sh + 1'b1;
    pkt_nxt.zero  = zero;
  end

  assign up_rdy = !valid_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_rdy) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_valid) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_pkt   = pkt_r;

endmodule

@@ rtl/gpr_cell.sv @@
// One reduction cell: if steps remain, clears one coefficient of the partial remainder
// and shifts the divisor down one place, else passes it on. Depends on gpr_pkg.
module gpr_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_rdy,
  input  gpr_pkg::pkt_t up_pkt,
  output logic          dn_valid,
  input  logic          dn_rdy,
  output gpr_pkg::pkt_t dn_pkt
);

  gpr_pkg::pkt_t pkt_nxt;
  gpr_pkg::pkt_t pkt_r;
  logic          valid_r;
  logic          act;
  logic          hit;

  always_comb begin
    act     = (up_pkt.cnt != '0);
    hit     = |(up_pkt.num & up_pkt.probe);
    pkt_nxt = up_pkt;
    if (act) begin
      // The divisor's leading term sits under the probe, so the XOR clears that bit.
      if (hit) begin
        pkt_nxt.num = up_pkt.num ^ up_pkt.den;
      end
      pkt_nxt.den   = up_pkt.den >> 1;
      pkt_nxt.probe = up_pkt.probe >> 1;
      pkt_nxt.cnt   = up_pkt.cnt - 1'b1;
    end
  end

  assign up_rdy = !valid_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_rdy) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_valid) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_pkt   = pkt_r;

endmodule
